>>> rtl/rgb16_alpha_blend_macros.svh
// assertion macros for the rgb16 alpha blender
`ifndef RGB16_ALPHA_BLEND_MACROS_SVH
`define RGB16_ALPHA_BLEND_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define RGBAB_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rgb16_alpha_blend: assertion failed");
// next-cycle implication
`define RGBAB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rgb16_alpha_blend: assertion failed");
`else
`define RGBAB_ASSERT_SAME(label, clk, rst, ante, cons)
`define RGBAB_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

>>> rtl/rgbab_pkg.sv
`timescale 1ns / 1ps

package rgbab_pkg;

  localparam int unsigned PIX_W   = 16;
  localparam int unsigned ALPHA_W = 8;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;

  localparam logic [PIX_W-1:0] MASK_R_565 = 16'hF800;
  localparam logic [PIX_W-1:0] MASK_G_565 = 16'h07E0;
  localparam logic [PIX_W-1:0] MASK_R_555 = 16'h7C00;
  localparam logic [PIX_W-1:0] MASK_G_555 = 16'h03E0;
  localparam logic [PIX_W-1:0] MASK_B     = 16'h001F;

  localparam logic [ALPHA_W-1:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [ALPHA_W-1:0] ALPHA_CLEAR  = 8'h00;

  // blend modes
  localparam logic [1:0] MODE_OVER  = 2'd0;
  localparam logic [1:0] MODE_THREE = 2'd1;
  localparam logic [1:0] MODE_CONST = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONST_ALPHA = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_555 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_555 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BKG_555 = 3'd4;

  typedef enum logic [1:0] {
    CH_RED,
    CH_GREEN,
    CH_BLUE
  } channel_t;

  typedef struct packed {
    logic [PIX_W-1:0]   source_pixel;
    logic [PIX_W-1:0]   dest_pixel;
    logic [PIX_W-1:0]   background_pixel;
    logic [ALPHA_W-1:0] alpha_value;
  } pixel_in_t;

  typedef struct packed {
    logic             write_enable;
    logic [PIX_W-1:0] out_pixel;
  } pixel_out_t;

  typedef struct packed {
    logic [1:0]         blend_mode;
    logic [ALPHA_W-1:0] constant_alpha;
    logic               source_is_555;
    logic               dest_is_555;
    logic               background_is_555;
  } cfg_t;

  function automatic logic [PIX_W-1:0] layout_mask(input logic is555, input channel_t ch);
    logic [PIX_W-1:0] m;
    case (ch)
      CH_RED:   m = is555 ? MASK_R_555 : MASK_R_565;
      CH_GREEN: m = is555 ? MASK_G_555 : MASK_G_565;
      default:  m = MASK_B;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/rgbab_cfg.sv
`timescale 1ns / 1ps

module rgbab_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rgbab_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rgbab_pkg::CFG_DATA_W-1:0]   cfg_data,
  output rgbab_pkg::cfg_t                    cfg
);
  import rgbab_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blend_mode        <= MODE_OVER;
      cfg.constant_alpha    <= ALPHA_OPAQUE;
      cfg.source_is_555     <= 1'b0;
      cfg.dest_is_555       <= 1'b0;
      cfg.background_is_555 <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLEND_MODE:  cfg.blend_mode        <= cfg_data[1:0];
        REG_CONST_ALPHA: cfg.constant_alpha    <= cfg_data;
        REG_SRC_555:     cfg.source_is_555     <= cfg_data[0];
        REG_DEST_555:    cfg.dest_is_555       <= cfg_data[0];
        REG_BKG_555:     cfg.background_is_555 <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/rgbab_chan.sv
`timescale 1ns / 1ps

module rgbab_chan (
  input  logic [rgbab_pkg::PIX_W-1:0]   src_pixel,
  input  logic [rgbab_pkg::PIX_W-1:0]   low_pixel,
  input  logic [rgbab_pkg::PIX_W-1:0]   src_mask,
  input  logic [rgbab_pkg::PIX_W-1:0]   low_mask,
  input  logic [rgbab_pkg::PIX_W-1:0]   dest_mask,
  input  logic [rgbab_pkg::ALPHA_W:0]   alpha_p1,
  output logic [rgbab_pkg::PIX_W-1:0]   chan_bits
);
  import rgbab_pkg::*;

  logic signed [PIX_W:0]         s;
  logic signed [PIX_W:0]         d;
  logic signed [PIX_W:0]         diff;
  logic signed [ALPHA_W+1:0]     a;
  logic signed [PIX_W+ALPHA_W+2:0] prod;
  logic signed [PIX_W+2:0]       sum;

  // channel bits stay in place, no shift down
  assign s    = $signed({1'b0, src_pixel & src_mask});
  assign d    = $signed({1'b0, low_pixel & low_mask});
  assign diff = s - d;
  assign a    = $signed({1'b0, alpha_p1});
  assign prod = diff * a;
  // upper bits of the signed product give the floored divide by 256
  assign sum  = prod[PIX_W+ALPHA_W+2:ALPHA_W] + {{2{d[PIX_W]}}, d};
  assign chan_bits = sum[PIX_W-1:0] & dest_mask;

endmodule

>>> rtl/rgb16_alpha_blend.sv
`timescale 1ns / 1ps
// rgb16_alpha_blend: from start to done a pixel passes the input register, then the result register
// throughput one pixel per clock while busy is low; three channel multiplies run in parallel in one stage
// busy is high during reset and for the first cycle after it, low otherwise
// rst is synchronous: clears the pipeline valids and loads the register reset values
// done strobes for one cycle per pixel; the receiver cannot stall
`include "rgb16_alpha_blend_macros.svh"

module rgb16_alpha_blend (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  rgbab_pkg::pixel_in_t              in_item,
  output logic                              done,
  output rgbab_pkg::pixel_out_t             result,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rgbab_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rgbab_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rgbab_pkg::*;

  cfg_t             cfg;
  logic             s1_valid;
  pixel_in_t        s1;
  logic             accept;
  logic [ALPHA_W:0] alpha_p1;
  logic [PIX_W-1:0] low_pixel;
  logic             low_is_555;
  logic [PIX_W-1:0] blend_pixel;
  logic [2:0][PIX_W-1:0] chan_bits;
  pixel_out_t       result_next;

  rgbab_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      s1_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      busy     <= 1'b0;
      s1_valid <= accept;
      done     <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= in_item;
    end
    result <= result_next;
  end

  always_comb begin
    if (cfg.blend_mode == MODE_CONST) begin
      alpha_p1 = {1'b0, cfg.constant_alpha} + 9'd1;
    end else begin
      alpha_p1 = {1'b0, s1.alpha_value} + 9'd1;
    end
    if (cfg.blend_mode == MODE_THREE) begin
      low_pixel  = s1.background_pixel;
      low_is_555 = cfg.background_is_555;
    end else begin
      low_pixel  = s1.dest_pixel;
      low_is_555 = cfg.dest_is_555;
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_chan
    rgbab_chan u_chan (
      .src_pixel (s1.source_pixel),
      .low_pixel (low_pixel),
      .src_mask  (layout_mask(cfg.source_is_555, channel_t'(k))),
      .low_mask  (layout_mask(low_is_555, channel_t'(k))),
      .dest_mask (layout_mask(cfg.dest_is_555, channel_t'(k))),
      .alpha_p1  (alpha_p1),
      .chan_bits (chan_bits[k])
    );
  end

  assign blend_pixel = chan_bits[0] | chan_bits[1] | chan_bits[2];

  always_comb begin
    result_next.write_enable = 1'b1;
    result_next.out_pixel    = s1.dest_pixel;
    case (cfg.blend_mode)
      MODE_OVER: begin
        if (s1.alpha_value == ALPHA_OPAQUE) begin
          result_next.out_pixel = s1.source_pixel;
        end else if (s1.alpha_value == ALPHA_CLEAR) begin
          result_next.write_enable = 1'b0;
        end else begin
          result_next.out_pixel = blend_pixel;
        end
      end
      MODE_THREE: begin
        if (s1.alpha_value == ALPHA_OPAQUE) begin
          result_next.out_pixel = s1.source_pixel;
        end else if (s1.alpha_value == ALPHA_CLEAR) begin
          result_next.out_pixel = s1.background_pixel;
        end else begin
          result_next.out_pixel = blend_pixel;
        end
      end
      MODE_CONST: begin
        result_next.out_pixel = blend_pixel;
      end
      default: begin
        result_next.write_enable = 1'b0;
      end
    endcase
  end

  // every transfer yields exactly one strobe, after the input register and the result register
  `RGBAB_ASSERT_NEXT(a_latency, clk, rst, accept, ##1 done)
  `RGBAB_ASSERT_SAME(a_no_spurious, clk, rst, done, $past(accept, 2))
  // alpha over destination with clear alpha never writes
  `RGBAB_ASSERT_NEXT(a_clear_drop, clk, rst,
    s1_valid && cfg.blend_mode == MODE_OVER && s1.alpha_value == ALPHA_CLEAR,
    !result.write_enable)
  // opaque alpha in the per-pixel modes copies the source as is
  `RGBAB_ASSERT_NEXT(a_opaque_copy, clk, rst,
    s1_valid && (cfg.blend_mode == MODE_OVER || cfg.blend_mode == MODE_THREE) &&
    s1.alpha_value == ALPHA_OPAQUE,
    result.out_pixel == $past(s1.source_pixel))

endmodule

>>> bench/rgb16_alpha_blend_tb.sv
`timescale 1ns / 1ps

module rgb16_alpha_blend_tb;
  import rgbab_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 1000;
  localparam int RANDOM_PHASES = 9;
  localparam int PIXELS_PER_PHASE = 50;

  typedef struct packed {
    cfg_t       cfg;
    pixel_in_t  px;
    logic       fixed;
    pixel_out_t want;
  } directed_row_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  pixel_in_t  in_item;
  logic       done;
  pixel_out_t result;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cfg_t          blend_cfg;
  pixel_out_t    expected_pixels[$];
  directed_row_t directed_rows[$];
  int            mismatch_count;
  int            result_count;
  int            stall_cycles;

  rgb16_alpha_blend dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .done(done),
    .result(result),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [PIX_W-1:0] chan_mask(logic is555, channel_t ch);
    logic [PIX_W-1:0] m;
    m = MASK_B;
    if (ch == CH_RED) begin
      m = is555 ? MASK_R_555 : MASK_R_565;
    end else if (ch == CH_GREEN) begin
      m = is555 ? MASK_G_555 : MASK_G_565;
    end
    return m;
  endfunction

  // per channel: floor((s - d) * weight / 256) + d, masked to the destination layout
  function automatic logic [PIX_W-1:0] blend_over(logic [PIX_W-1:0] top, logic top555,
                                                  logic [PIX_W-1:0] under, logic under555,
                                                  int weight);
    logic [PIX_W-1:0] mixed;
    channel_t ch;
    int s;
    int d;
    int v;
    int k;
    mixed = '0;
    for (k = 0; k < 3; k++) begin
      ch = channel_t'(k);
      s = int'(top & chan_mask(top555, ch));
      d = int'(under & chan_mask(under555, ch));
      v = (((s - d) * weight) >>> 8) + d;
      mixed = mixed | (v[PIX_W-1:0] & chan_mask(blend_cfg.dest_is_555, ch));
    end
    return mixed;
  endfunction

  function automatic pixel_out_t predict_result(pixel_in_t px);
    pixel_out_t r;
    r.write_enable = 1'b1;
    r.out_pixel = px.dest_pixel;
    case (blend_cfg.blend_mode)
      MODE_OVER: begin
        if (px.alpha_value == ALPHA_OPAQUE) begin
          r.out_pixel = px.source_pixel;
        end else if (px.alpha_value == ALPHA_CLEAR) begin
          r.write_enable = 1'b0;
        end else begin
          r.out_pixel = blend_over(px.source_pixel, blend_cfg.source_is_555, px.dest_pixel,
                                   blend_cfg.dest_is_555, int'(px.alpha_value) + 1);
        end
      end
      MODE_THREE: begin
        if (px.alpha_value == ALPHA_OPAQUE) begin
          r.out_pixel = px.source_pixel;
        end else if (px.alpha_value == ALPHA_CLEAR) begin
          r.out_pixel = px.background_pixel;
        end else begin
          r.out_pixel = blend_over(px.source_pixel, blend_cfg.source_is_555,
                                   px.background_pixel, blend_cfg.background_is_555,
                                   int'(px.alpha_value) + 1);
        end
      end
      MODE_CONST: begin
        r.out_pixel = blend_over(px.source_pixel, blend_cfg.source_is_555, px.dest_pixel,
                                 blend_cfg.dest_is_555, int'(blend_cfg.constant_alpha) + 1);
      end
      default: begin
        r.write_enable = 1'b0;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("result %0d: %s", result_count, msg);
    mismatch_count++;
  endtask

  // keeps cfg_valid high across back-to-back writes; caller lowers it
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BLEND_MODE:  blend_cfg.blend_mode = data[1:0];
      REG_CONST_ALPHA: blend_cfg.constant_alpha = data;
      REG_SRC_555:     blend_cfg.source_is_555 = data[0];
      REG_DEST_555:    blend_cfg.dest_is_555 = data[0];
      REG_BKG_555:     blend_cfg.background_is_555 = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_config(cfg_t c);
    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    write_reg(REG_BLEND_MODE, {6'b0, c.blend_mode});
    write_reg(REG_CONST_ALPHA, c.constant_alpha);
    write_reg(REG_SRC_555, {7'b0, c.source_is_555});
    write_reg(REG_DEST_555, {7'b0, c.dest_is_555});
    write_reg(REG_BKG_555, {7'b0, c.background_is_555});
    cfg_valid <= 1'b0;
  endtask

  // start stays high when the next pixel follows with no gap
  task automatic send_pixel(pixel_in_t px, int gap, logic fixed, pixel_out_t want);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= px;
    do @(posedge clk); while (busy);
    expected_pixels.push_back(fixed ? want : predict_result(px));
  endtask

  task automatic add_row(cfg_t c, logic [15:0] src, logic [15:0] dst, logic [15:0] bkg,
                         logic [7:0] alpha, logic fixed, logic we, logic [15:0] pix);
    directed_row_t row;
    row.cfg = c;
    row.px = '{src, dst, bkg, alpha};
    row.fixed = fixed;
    row.want = '{we, pix};
    directed_rows.push_back(row);
  endtask

  function automatic logic [PIX_W-1:0] random_pixel_value();
    logic [PIX_W-1:0] v;
    v = PIX_W'($urandom);
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      default: ;
    endcase
    return v;
  endfunction

  function automatic pixel_in_t random_pixel();
    pixel_in_t px;
    px.source_pixel = random_pixel_value();
    px.dest_pixel = random_pixel_value();
    px.background_pixel = random_pixel_value();
    case ($urandom_range(0, 19))
      0, 1:    px.alpha_value = ALPHA_CLEAR;
      2, 3:    px.alpha_value = ALPHA_OPAQUE;
      4:       px.alpha_value = 8'd1;
      5:       px.alpha_value = 8'd254;
      default: px.alpha_value = ALPHA_W'($urandom);
    endcase
    return px;
  endfunction

  // result checker: done is sampled as it stood before the edge
  always @(posedge clk) begin
    pixel_out_t exp_px;
    if (!rst && done === 1'b1) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected result we=%b pixel=%h",
                                  result.write_enable, result.out_pixel));
      end else begin
        exp_px = expected_pixels.pop_front();
        if (result.write_enable !== exp_px.write_enable) begin
          report_mismatch($sformatf("write_enable got %b want %b",
                                    result.write_enable, exp_px.write_enable));
        end
        if (result.out_pixel !== exp_px.out_pixel) begin
          report_mismatch($sformatf("out_pixel got %h want %h",
                                    result.out_pixel, exp_px.out_pixel));
        end
      end
      result_count++;
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("rgb16_alpha_blend: mismatch");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    cfg_t c;
    cfg_t reset_cfg;
    pixel_out_t none;
    directed_row_t row;
    logic idle_on;
    int gap;
    int phase;
    int i;

    clk = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    in_item = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatch_count = 0;
    result_count = 0;
    stall_cycles = 0;
    none = '0;
    reset_cfg = '{MODE_OVER, 8'd255, 1'b0, 1'b0, 1'b0};
    blend_cfg = reset_cfg;

    // alpha over destination, reset layout
    c = reset_cfg;
    add_row(c, 16'hFFFF, 16'h0000, 16'h1234, ALPHA_OPAQUE, 1'b1, 1'b1, 16'hFFFF);
    add_row(c, 16'hFFFF, 16'hA5A5, 16'hFFFF, ALPHA_CLEAR, 1'b1, 1'b0, 16'hA5A5);
    add_row(c, 16'hFFFF, 16'h0000, 16'h0000, 8'd1, 1'b0, 1'b0, 16'h0);
    add_row(c, 16'h0000, 16'hFFFF, 16'h0000, 8'd254, 1'b0, 1'b0, 16'h0);
    add_row(c, 16'h1234, 16'hABCD, 16'h5A5A, 8'd128, 1'b0, 1'b0, 16'h0);
    add_row(c, 16'h0000, 16'h0000, 16'h0000, ALPHA_OPAQUE, 1'b1, 1'b1, 16'h0000);
    // three-way with background
    c.blend_mode = MODE_THREE;
    add_row(c, 16'hC3C3, 16'h1111, 16'h2222, ALPHA_OPAQUE, 1'b1, 1'b1, 16'hC3C3);
    add_row(c, 16'hC3C3, 16'h1111, 16'h2222, ALPHA_CLEAR, 1'b1, 1'b1, 16'h2222);
    add_row(c, 16'hFFFF, 16'hFFFF, 16'h0000, 8'd1, 1'b0, 1'b0, 16'h0);
    add_row(c, 16'h0000, 16'h0000, 16'hFFFF, 8'd200, 1'b0, 1'b0, 16'h0);
    // constant alpha at both ends
    c.blend_mode = MODE_CONST;
    add_row(c, 16'hFFFF, 16'h0000, 16'h0000, ALPHA_CLEAR, 1'b0, 1'b0, 16'h0);
    add_row(c, 16'h0000, 16'hFFFF, 16'hFFFF, ALPHA_OPAQUE, 1'b0, 1'b0, 16'h0);
    c.constant_alpha = 8'd0;
    add_row(c, 16'hFFFF, 16'h0000, 16'h0000, ALPHA_OPAQUE, 1'b0, 1'b0, 16'h0);
    add_row(c, 16'h0000, 16'hFFFF, 16'h0000, 8'd77, 1'b0, 1'b0, 16'h0);
    // mixed layouts: 555 source over 565 destination and the reverse
    c = '{MODE_OVER, 8'd255, 1'b1, 1'b0, 1'b0};
    add_row(c, 16'h7FFF, 16'h0000, 16'h0000, 8'd100, 1'b0, 1'b0, 16'h0);
    add_row(c, 16'hFFFF, 16'hFFFF, 16'h0000, 8'd31, 1'b0, 1'b0, 16'h0);
    c = '{MODE_OVER, 8'd255, 1'b0, 1'b1, 1'b0};
    add_row(c, 16'hFFFF, 16'h8000, 16'h0000, 8'd100, 1'b0, 1'b0, 16'h0);
    c = '{MODE_THREE, 8'd255, 1'b0, 1'b1, 1'b1};
    add_row(c, 16'hF800, 16'hFFFF, 16'h7C00, 8'd50, 1'b0, 1'b0, 16'h0);
    add_row(c, 16'h07E0, 16'h0000, 16'hFFFF, 8'd180, 1'b0, 1'b0, 16'h0);
    // unused mode leaves the destination alone
    c = '{MODE_UNUSED, 8'd255, 1'b0, 1'b0, 1'b0};
    add_row(c, 16'hFFFF, 16'h1357, 16'h2468, ALPHA_OPAQUE, 1'b1, 1'b0, 16'h1357);
    add_row(c, 16'hFFFF, 16'hFFFF, 16'h0000, ALPHA_CLEAR, 1'b1, 1'b0, 16'hFFFF);
    add_row(c, 16'h0F0F, 16'h0000, 16'hFFFF, 8'd90, 1'b1, 1'b0, 16'h0000);
    c = '{MODE_CONST, 8'd127, 1'b1, 1'b1, 1'b1};
    add_row(c, 16'h7FFF, 16'h0000, 16'h0000, 8'd3, 1'b0, 1'b0, 16'h0);
    add_row(c, 16'h0000, 16'h7FFF, 16'hFFFF, 8'd3, 1'b0, 1'b0, 16'h0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (i = 0; i < directed_rows.size(); i++) begin
      row = directed_rows[i];
      if (i == 0 || row.cfg != blend_cfg) begin
        apply_config(row.cfg);
      end
      gap = (i % 2 == 0) ? 0 : $urandom_range(0, 15);
      send_pixel(row.px, gap, row.fixed, row.want);
    end

    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      c.blend_mode = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 2));
      c.constant_alpha = ALPHA_W'($urandom);
      if (phase == 4) begin
        c.constant_alpha = 8'd0;
      end else if (phase == 5) begin
        c.constant_alpha = 8'd255;
      end
      if (phase >= 4 && phase <= 6) begin
        c.blend_mode = MODE_CONST;
      end
      c.source_is_555 = 1'($urandom);
      c.dest_is_555 = 1'($urandom);
      c.background_is_555 = 1'($urandom);
      apply_config(c);
      // every third phase streams with no gaps at all
      idle_on = (phase % 3 != 2);
      for (i = 0; i < PIXELS_PER_PHASE; i++) begin
        gap = 0;
        if (idle_on && $urandom_range(0, 1) == 1) begin
          gap = $urandom_range(0, 15);
        end
        send_pixel(random_pixel(), gap, 1'b0, none);
      end
    end

    start <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("rgb16_alpha_blend: match");
    end else begin
      $display("rgb16_alpha_blend: mismatch");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/rgbab_pkg.sv
rtl/rgbab_cfg.sv
rtl/rgbab_chan.sv
rtl/rgb16_alpha_blend.sv
bench/rgb16_alpha_blend_tb.sv
